/* rtl/uart_tx_rx_ring_buffers_core_defines.svh */
// Assertion macros for the serial-port ring buffer block.
// Used only by the top level; needs nothing else.
`ifndef UART_TX_RX_RING_BUFFERS_CORE_DEFINES_SVH
`define UART_TX_RX_RING_BUFFERS_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define UTRB_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("utrb: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define UTRB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("utrb: next-cycle check failed");

`endif

/* rtl/utrb_pkg.sv */
// Shared types and constants for the serial-port ring buffer block.
// No dependencies; used by utrb_skid and uart_tx_rx_ring_buffers_core.
package utrb_pkg;

    localparam int DEPTH_DEFAULT = 32;

    typedef enum logic [1:0] {
        OP_HOST_WRITE = 2'd0,
        OP_HOST_READ  = 2'd1,
        OP_TX_READY   = 2'd2,
        OP_LINE_RX    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_TX_FULL  = 2'd1,
        ST_RX_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic       tx_request;
        logic       rx_overrun;
        logic [7:0] tx_data;
        logic       tx_valid;
        logic [7:0] read_data;
        status_t    status;
    } result_t;

endpackage

/* rtl/utrb_skid.sv */
// Two-entry skid buffer for result transactions; registered output.
// Depends on utrb_pkg (result_t).
module utrb_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  utrb_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output utrb_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              spare_valid_reg;
    utrb_pkg::result_t out_data_reg;
    utrb_pkg::result_t spare_data_reg;
    logic              out_free;

    assign in_ready  = !spare_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = out_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (spare_valid_reg)
            begin
                out_valid_reg   <= 1'b1;
                spare_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid && !spare_valid_reg)
        begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= spare_valid_reg ? spare_data_reg : in_data;
        end
        else if (in_valid && !spare_valid_reg)
        begin
            spare_data_reg <= in_data;
        end
    end

endmodule

/* rtl/uart_tx_rx_ring_buffers_core.sv */
// Serial-port transmit and receive byte rings, DEPTH entries each (DEPTH-1 usable).
// Path: a result goes through the pipe register, then the skid output register, to m_*.
// Throughput: one transaction per cycle unless m_tready stalls; each touches one store entry per ring port.
// Reset: ring pointers and the transmit-request flag clear; store contents stay
// undefined and need no clearing pass, since no entry's byte is used before it is written.
`include "uart_tx_rx_ring_buffers_core_defines.svh"
module uart_tx_rx_ring_buffers_core
#(
    parameter int DEPTH = utrb_pkg::DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Command side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // Result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] read_data, [8] tx_valid, [16:9] tx_data,
                                   // [17] rx_overrun, [18] tx_request, [23:19] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // Ring index advance with wrap at DEPTH.
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
        logic [PTR_W-1:0] res;
        res = (idx == PTR_LAST) ? '0 : idx + PTR_W'(1);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Ring state
    // ---------------------------------------------------------------
    logic [PTR_W-1:0] tx_head_reg, tx_head_next;
    logic [PTR_W-1:0] tx_tail_reg, tx_tail_next;
    logic [PTR_W-1:0] rx_head_reg, rx_head_next;
    logic [PTR_W-1:0] rx_tail_reg, rx_tail_next;
    logic             tx_req_reg, tx_req_next;

    logic [7:0] tx_mem [DEPTH];
    logic [7:0] rx_mem [DEPTH];

    // Pipe register: flags of the accepted transaction plus registered store reads.
    logic               st_valid_reg, st_valid_next;
    utrb_pkg::status_t  st_status_reg, st_status_next;
    logic               st_rd_sel_reg, st_rd_sel_next;
    logic               st_tx_valid_reg, st_tx_valid_next;
    logic               st_overrun_reg, st_overrun_next;
    logic               st_tx_req_reg;
    logic [7:0]         tx_rd_reg;
    logic [7:0]         rx_rd_reg;

    logic              s_fire;
    logic              sk_in_ready;
    logic              st_take;
    logic              tx_wr_en;
    logic              rx_wr_en;
    logic              tx_full;
    logic              tx_empty;
    logic              rx_full;
    logic              rx_empty;
    utrb_pkg::op_t     op;
    utrb_pkg::result_t st_result;
    utrb_pkg::result_t out_result;

    assign op       = utrb_pkg::op_t'(s_tuser);
    assign tx_full  = (ring_next(tx_head_reg) == tx_tail_reg);
    assign tx_empty = (tx_head_reg == tx_tail_reg);
    assign rx_full  = (ring_next(rx_head_reg) == rx_tail_reg);
    assign rx_empty = (rx_head_reg == rx_tail_reg);

    // Pipe register frees when the skid stage takes its result; skid readiness is
    // registered, so no combinational path runs from m_tready to s_tready.
    assign st_take  = st_valid_reg && sk_in_ready;
    assign s_tready = !st_valid_reg || sk_in_ready;
    assign s_fire   = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Per-transaction decode: pointer moves, flag, result flags
    // ---------------------------------------------------------------
    always_comb
    begin
        tx_head_next     = tx_head_reg;
        tx_tail_next     = tx_tail_reg;
        rx_head_next     = rx_head_reg;
        rx_tail_next     = rx_tail_reg;
        tx_req_next      = tx_req_reg;
        st_status_next   = utrb_pkg::ST_DONE;
        st_rd_sel_next   = 1'b0;
        st_tx_valid_next = 1'b0;
        st_overrun_next  = 1'b0;
        tx_wr_en         = 1'b0;
        rx_wr_en         = 1'b0;
        unique case (op)
            utrb_pkg::OP_HOST_WRITE:
            begin
                if (tx_full)
                begin
                    st_status_next = utrb_pkg::ST_TX_FULL;
                end
                else
                begin
                    tx_wr_en     = 1'b1;
                    tx_head_next = ring_next(tx_head_reg);
                    tx_req_next  = 1'b1;
                end
            end
            utrb_pkg::OP_HOST_READ:
            begin
                if (rx_empty)
                begin
                    st_status_next = utrb_pkg::ST_RX_EMPTY;
                end
                else
                begin
                    st_rd_sel_next = 1'b1;
                    rx_tail_next   = ring_next(rx_tail_reg);
                end
            end
            utrb_pkg::OP_TX_READY:
            begin
                if (tx_empty)
                begin
                    tx_req_next = 1'b0;
                end
                else
                begin
                    st_tx_valid_next = 1'b1;
                    tx_tail_next     = ring_next(tx_tail_reg);
                end
            end
            utrb_pkg::OP_LINE_RX:
            begin
                // Full ring: drop the oldest unread byte to make room.
                if (rx_full)
                begin
                    rx_tail_next    = ring_next(rx_tail_reg);
                    st_overrun_next = 1'b1;
                end
                rx_wr_en     = 1'b1;
                rx_head_next = ring_next(rx_head_reg);
            end
        endcase

        if (s_fire)
        begin
            st_valid_next = 1'b1;
        end
        else if (st_take)
        begin
            st_valid_next = 1'b0;
        end
        else
        begin
            st_valid_next = st_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            tx_req_reg   <= 1'b0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
            if (s_fire)
            begin
                tx_head_reg <= tx_head_next;
                tx_tail_reg <= tx_tail_next;
                rx_head_reg <= rx_head_next;
                rx_tail_reg <= rx_tail_next;
                tx_req_reg  <= tx_req_next;
            end
        end
    end

    // Result flags; payload, so no reset.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            st_status_reg   <= st_status_next;
            st_rd_sel_reg   <= st_rd_sel_next;
            st_tx_valid_reg <= st_tx_valid_next;
            st_overrun_reg  <= st_overrun_next;
            st_tx_req_reg   <= tx_req_next;
        end
    end

    // ---------------------------------------------------------------
    // Byte stores: one write and one registered read per ring per cycle.
    // Reads use the tail before this transaction moves it; no transaction both
    // writes a ring and uses the byte read from that same ring.
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_fire && tx_wr_en)
        begin
            tx_mem[tx_head_reg] <= s_tdata;
        end
        if (s_fire)
        begin
            tx_rd_reg <= tx_mem[tx_tail_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && rx_wr_en)
        begin
            rx_mem[rx_head_reg] <= s_tdata;
        end
        if (s_fire)
        begin
            rx_rd_reg <= rx_mem[rx_tail_reg];
        end
    end

    // Unused byte fields read as zero.
    always_comb
    begin
        st_result.status     = st_status_reg;
        st_result.read_data  = st_rd_sel_reg ? rx_rd_reg : 8'd0;
        st_result.tx_valid   = st_tx_valid_reg;
        st_result.tx_data    = st_tx_valid_reg ? tx_rd_reg : 8'd0;
        st_result.rx_overrun = st_overrun_reg;
        st_result.tx_request = st_tx_req_reg;
    end

    utrb_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid_reg),
        .in_ready  (sk_in_ready),
        .in_data   (st_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tuser = out_result.status;
    assign m_tdata = {5'd0, out_result.tx_request, out_result.rx_overrun,
                      out_result.tx_data, out_result.tx_valid, out_result.read_data};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A queued byte always leaves the transmit request raised.
    `UTRB_ASSERT_NOW(a_req_when_queued, clk, rst_n, tx_head_reg != tx_tail_reg, tx_req_reg)
    // A refused host write leaves the transmit ring untouched.
    `UTRB_ASSERT_NEXT(a_refused_write_holds, clk, rst_n,
        s_fire && op == utrb_pkg::OP_HOST_WRITE && tx_full,
        $stable(tx_head_reg) && $stable(tx_tail_reg))
    // After a line byte the receive ring is never empty.
    `UTRB_ASSERT_NEXT(a_rx_nonempty, clk, rst_n,
        s_fire && op == utrb_pkg::OP_LINE_RX, rx_head_reg != rx_tail_reg)
    // A delivered transmit byte comes with a done status.
    `UTRB_ASSERT_NOW(a_tx_done, clk, rst_n, m_tvalid && m_tdata[8], m_tuser == utrb_pkg::ST_DONE)

endmodule
